// ===== rtl/pttt_pkg.sv =====
package pttt_pkg;

	// Table size and derived widths.
	localparam int MAX_TASKS   = 8;
	localparam int MAX_RESULTS = 8;
	localparam int IDX_W       = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W       = $clog2(MAX_TASKS + 1);
	localparam int RES_W       = $clog2(MAX_RESULTS + 1);

	// Depth of the queue between the front and back parts.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Opcodes of an input item.
	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_ADD  = 2'd1;
	localparam logic [1:0] OP_DEL  = 2'd2;
	localparam logic [1:0] OP_NOP  = 2'd3;

	// Result status codes.
	localparam logic [2:0] STAT_DUE      = 3'd0;
	localparam logic [2:0] STAT_NONE     = 3'd1;
	localparam logic [2:0] STAT_ADDED    = 3'd2;
	localparam logic [2:0] STAT_FULL     = 3'd3;
	localparam logic [2:0] STAT_DELETED  = 3'd4;
	localparam logic [2:0] STAT_NOTFOUND = 3'd5;

	// Classified command passed from the front part to the back part.
	typedef enum logic [1:0] {
		CMD_TICK,
		CMD_ADD,
		CMD_DEL,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  task_id;
		logic [15:0] reload;
	} cmd_t;

endpackage

// ===== rtl/pttt_front.sv =====
module pttt_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       opcode,
	input  logic [7:0]       task_id,
	input  logic [15:0]      period,
	input  logic [7:0]       priority_req,
	output logic             cmd_valid,
	output pttt_pkg::cmd_t   cmd,
	input  logic             q_full
);
	import pttt_pkg::*;

	logic  valid_s1;
	cmd_t  cmd_s1;
	cmd_t  cmd_new;
	logic  accept;
	logic  move;

	// The held item moves on once the queue has room.
	assign move      = valid_s1 && !q_full;
	assign busy      = valid_s1 && q_full;
	assign accept    = start && !busy;
	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	// Classify the item and work out the reload value of an add.
	always_comb begin
		cmd_new.task_id = task_id;
		cmd_new.reload  = period + {8'd0, priority_req};
		unique case (opcode)
			OP_TICK: cmd_new.kind = CMD_TICK;
			OP_ADD:  cmd_new.kind = CMD_ADD;
			OP_DEL:  cmd_new.kind = CMD_DEL;
			OP_NOP:  cmd_new.kind = CMD_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload needs no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_new;
		end
	end

endmodule

// ===== rtl/pttt_queue.sv =====
module pttt_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pttt_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output pttt_pkg::cmd_t pop_cmd,
	output logic           empty
);
	import pttt_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (cnt_q == QCNT_W'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_cmd = mem_q[rd_ptr_q];

	// Pointers wrap at the queue depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== rtl/pttt_back.sv =====
module pttt_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_avail,
	input  pttt_pkg::cmd_t cmd,
	output logic           pop,
	output logic           done,
	output logic [2:0]     status,
	output logic [7:0]     due_id,
	output logic           last
);
	import pttt_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_TICK  = 3'd1;
	localparam logic [2:0] S_FIN   = 3'd2;
	localparam logic [2:0] S_SRCH  = 3'd3;
	localparam logic [2:0] S_SHIFT = 3'd4;

	// Task table.
	logic [7:0]  id_q  [MAX_TASKS];
	logic [15:0] per_q [MAX_TASKS];
	logic [15:0] cd_q  [MAX_TASKS];

	logic [2:0]       state_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0]       tgt_q;
	logic             pend_valid_q;
	logic [7:0]       pend_id_q;
	logic [RES_W-1:0] nres_q;
	logic             done_q;
	logic [2:0]       status_q;
	logic [7:0]       due_id_q;
	logic             last_q;

	logic [IDX_W-1:0] rd_idx;
	logic [7:0]       rd_id;
	logic [15:0]      rd_per;
	logic [15:0]      rd_cd;
	logic             last_entry;
	logic             shift_end;
	logic             is_due;
	logic             room;
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic [7:0]       wr_id;
	logic [15:0]      wr_per;
	logic [15:0]      wr_cd;

	assign pop    = (state_q == S_IDLE) && cmd_avail;
	assign done   = done_q;
	assign status = status_q;
	assign due_id = due_id_q;
	assign last   = last_q;

	// One read port: the entry after the cursor while shifting, else the cursor entry.
	assign rd_idx     = (state_q == S_SHIFT) ? idx_q + 1'b1 : idx_q;
	assign rd_id      = id_q[rd_idx];
	assign rd_per     = per_q[rd_idx];
	assign rd_cd      = cd_q[rd_idx];
	assign last_entry = (CNT_W'(idx_q) + 1'b1 == count_q);
	assign shift_end  = (CNT_W'(idx_q) + CNT_W'(2) == count_q);
	assign is_due     = (rd_cd == 16'd0);
	assign room       = (nres_q < RES_W'(MAX_RESULTS));

	// Single write port into the table.
	always_comb begin
		wr_en  = 1'b0;
		wr_idx = idx_q;
		wr_id  = rd_id;
		wr_per = rd_per;
		wr_cd  = rd_cd;
		unique case (state_q)
			S_IDLE: begin
				if (pop && cmd.kind == CMD_ADD && count_q < CNT_W'(MAX_TASKS)) begin
					wr_en  = 1'b1;
					wr_idx = count_q[IDX_W-1:0];
					wr_id  = cmd.task_id;
					wr_per = cmd.reload;
					wr_cd  = cmd.reload;
				end
			end
			S_TICK: begin
				wr_en = 1'b1;
				wr_cd = (is_due ? rd_per : rd_cd) - 16'd1;
			end
			S_SHIFT: begin
				wr_en = 1'b1;
			end
			S_FIN, S_SRCH: begin
				wr_en = 1'b0;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			id_q[wr_idx]  <= wr_id;
			per_q[wr_idx] <= wr_per;
			cd_q[wr_idx]  <= wr_cd;
		end
	end

	// Sequencer: runs one command at a time and drives the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			count_q      <= '0;
			tgt_q        <= '0;
			pend_valid_q <= 1'b0;
			pend_id_q    <= '0;
			nres_q       <= '0;
			done_q       <= 1'b0;
			status_q     <= STAT_NONE;
			due_id_q     <= '0;
			last_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						unique case (cmd.kind)
							CMD_TICK: begin
								if (count_q == '0) begin
									done_q   <= 1'b1;
									status_q <= STAT_NONE;
									due_id_q <= '0;
									last_q   <= 1'b1;
								end else begin
									idx_q        <= '0;
									nres_q       <= '0;
									pend_valid_q <= 1'b0;
									state_q      <= S_TICK;
								end
							end
							CMD_ADD: begin
								done_q   <= 1'b1;
								due_id_q <= '0;
								last_q   <= 1'b1;
								if (count_q < CNT_W'(MAX_TASKS)) begin
									count_q  <= count_q + 1'b1;
									status_q <= STAT_ADDED;
								end else begin
									status_q <= STAT_FULL;
								end
							end
							CMD_DEL: begin
								if (count_q == '0) begin
									done_q   <= 1'b1;
									status_q <= STAT_NOTFOUND;
									due_id_q <= '0;
									last_q   <= 1'b1;
								end else begin
									tgt_q   <= cmd.task_id;
									idx_q   <= '0;
									state_q <= S_SRCH;
								end
							end
							CMD_NOP: begin
								done_q   <= 1'b1;
								status_q <= STAT_NONE;
								due_id_q <= '0;
								last_q   <= 1'b1;
							end
						endcase
					end
				end
				S_TICK: begin
					// A new due entry releases the previous one, which is then not the last.
					if (is_due && room) begin
						if (pend_valid_q) begin
							done_q   <= 1'b1;
							status_q <= STAT_DUE;
							due_id_q <= pend_id_q;
							last_q   <= 1'b0;
						end
						pend_valid_q <= 1'b1;
						pend_id_q    <= rd_id;
						nres_q       <= nres_q + 1'b1;
					end
					if (last_entry) begin
						state_q <= S_FIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_FIN: begin
					done_q       <= 1'b1;
					last_q       <= 1'b1;
					pend_valid_q <= 1'b0;
					if (pend_valid_q) begin
						status_q <= STAT_DUE;
						due_id_q <= pend_id_q;
					end else begin
						status_q <= STAT_NONE;
						due_id_q <= '0;
					end
					state_q <= S_IDLE;
				end
				S_SRCH: begin
					if (rd_id == tgt_q) begin
						if (last_entry) begin
							count_q  <= count_q - 1'b1;
							done_q   <= 1'b1;
							status_q <= STAT_DELETED;
							due_id_q <= '0;
							last_q   <= 1'b1;
							state_q  <= S_IDLE;
						end else begin
							state_q <= S_SHIFT;
						end
					end else if (last_entry) begin
						done_q   <= 1'b1;
						status_q <= STAT_NOTFOUND;
						due_id_q <= '0;
						last_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_SHIFT: begin
					if (shift_end) begin
						count_q  <= count_q - 1'b1;
						done_q   <= 1'b1;
						status_q <= STAT_DELETED;
						due_id_q <= '0;
						last_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/periodic_task_tick_table.sv =====
// Channel   Handshake            Payload
// input     start / busy         opcode, task_id, period, priority_req
// result    done (one cycle)     status, due_id, last
//
// An item is registered by the front part, queued, then run by the back part, which
// registers its results.
// In the back part a tick over a non-empty table visits each entry in turn on the single
// read port, then gives the final result; a delete over a non-empty table searches up to
// the match, then shifts the rest down. After reset the table is empty and items are
// taken at once.
// busy rises only when the front register and the queue are both full; results
// cannot be stalled and appear for one cycle each.
module periodic_task_tick_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [7:0]  task_id,
	input  logic [15:0] period,
	input  logic [7:0]  priority_req,
	output logic        done,
	output logic [2:0]  status,
	output logic [7:0]  due_id,
	output logic        last
);
	import pttt_pkg::*;

	logic  fe_valid;
	cmd_t  fe_cmd;
	logic  q_full;
	logic  q_empty;
	logic  q_pop;
	cmd_t  q_cmd;

	// Front part: accepts and classifies items.
	pttt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.task_id      (task_id),
		.period       (period),
		.priority_req (priority_req),
		.cmd_valid    (fe_valid),
		.cmd          (fe_cmd),
		.q_full       (q_full)
	);

	// Command queue between the two parts.
	pttt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fe_valid),
		.push_cmd (fe_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.pop_cmd  (q_cmd),
		.empty    (q_empty)
	);

	// Back part: owns the task table and produces results.
	pttt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_avail (!q_empty),
		.cmd       (q_cmd),
		.pop       (q_pop),
		.done      (done),
		.status    (status),
		.due_id    (due_id),
		.last      (last)
	);

endmodule
